// File: src/sqtone_pkg.sv
package sqtone_pkg;

   // Command codes carried in req_tuser
   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   // Register map
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_ADDR_W-1:0] CSR_VOLUME = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_AMP    = 1'd1;

   localparam logic [6:0]  VOL_MAX     = 7'd100;
   localparam logic [6:0]  VOL_RESET   = 7'd100;
   // 28000 / 100, full scale per volume percent
   localparam logic [8:0]  AMP_PER_PCT = 9'd280;

   localparam logic [15:0] FREQ_MIN = 16'd100;
   localparam logic [15:0] FREQ_MAX = 16'd5000;
   localparam logic [15:0] DUR_MAX  = 16'd2000;

   localparam int          MS_PER_S = 1000;
   localparam int          MS_REM_W = 10;   // holds SAMPLE_RATE % 1000
   // floor(2^32 / 1000)
   localparam logic [22:0] MS_RECIP = 23'd4294967;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] tone_hz;
      logic [15:0] tone_ms;
      logic        sink_accepted;
   } item_type;

   // Packed so that sample sits in the low bits
   typedef struct packed {
      logic [15:0]        completed_count;
      logic [15:0]        rejected_count;
      logic               underrun;
      logic               playing;
      logic               start_accepted;
      logic               sample_valid;
      logic signed [15:0] sample;
   } rsp_type;

   localparam int RSP_W   = $bits(rsp_type);
   localparam int RSP_PAD = 56 - RSP_W;

endpackage

// File: src/sqtone_core.sv
module sqtone_core
   import sqtone_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  item_type              item,
   input  logic [31:0]           step_calc,
   input  logic [15:0]           count_calc,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output rsp_type               result
);

   logic [31:0] phase_ff, phase_in;
   logic [31:0] step_ff, step_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] rej_ff, rej_in;
   logic [15:0] done_ff, done_in;
   logic        playing_ff, playing_in;
   logic        under_ff, under_in;
   logic [6:0]  vol_ff, vol_in;
   logic        amp_ff, amp_in;

   logic [14:0] amp_level;
   logic [15:0] left_dec;
   logic        start_bad;

   always_comb begin
      amp_level = 15'(vol_ff * AMP_PER_PCT);
      left_dec  = left_ff - 16'd1;
      start_bad = !amp_ff || playing_ff ||
                  (item.tone_hz < FREQ_MIN) || (item.tone_hz > FREQ_MAX) ||
                  (item.tone_ms == 16'd0) || (item.tone_ms > DUR_MAX);

      phase_in   = phase_ff;
      step_in    = step_ff;
      left_in    = left_ff;
      rej_in     = rej_ff;
      done_in    = done_ff;
      playing_in = playing_ff;
      under_in   = under_ff;
      vol_in     = vol_ff;
      amp_in     = amp_ff;

      result = '0;

      if (step_en) begin
         unique case (item.cmd)
            CMD_START: begin
               if (start_bad) begin
                  rej_in = rej_ff + 16'd1;
               end else begin
                  phase_in              = '0;
                  step_in               = step_calc;
                  left_in               = count_calc;
                  playing_in            = (count_calc != '0);
                  under_in              = 1'b0;
                  result.start_accepted = (count_calc != '0);
               end
            end
            CMD_STOP: begin
               left_in    = '0;
               playing_in = 1'b0;
            end
            CMD_TICK: begin
               if (playing_ff && (left_ff != '0)) begin
                  result.sample_valid = 1'b1;
                  result.sample       = phase_ff[31] ? 16'({1'b0, amp_level})
                                                     : 16'(-{1'b0, amp_level});
                  phase_in = phase_ff + step_ff;
                  if (item.sink_accepted) begin
                     left_in = left_dec;
                     // last sample taken ends the tone
                     if (left_dec == '0) begin
                        playing_in = 1'b0;
                        done_in    = done_ff + 16'd1;
                     end
                  end else begin
                     under_in = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end

      result.playing         = playing_in;
      result.underrun        = under_in;
      result.rejected_count  = rej_in;
      result.completed_count = done_in;

      // the user must issue register writes only while no beat is in flight; the core does not enforce this
      if (csr_we) begin
         unique case (csr_addr)
            CSR_VOLUME: vol_in = (csr_wdata > VOL_MAX) ? VOL_MAX : csr_wdata;
            CSR_AMP: begin
               amp_in = csr_wdata[0];
               if (!csr_wdata[0]) begin
                  left_in    = '0;
                  playing_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         step_ff    <= '0;
         left_ff    <= '0;
         rej_ff     <= '0;
         done_ff    <= '0;
         playing_ff <= 1'b0;
         under_ff   <= 1'b0;
         vol_ff     <= VOL_RESET;
         amp_ff     <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         step_ff    <= step_in;
         left_ff    <= left_in;
         rej_ff     <= rej_in;
         done_ff    <= done_in;
         playing_ff <= playing_in;
         under_ff   <= under_in;
         vol_ff     <= vol_in;
         amp_ff     <= amp_in;
      end
   end

   a_playing_has_count: assert property (@(posedge clock) disable iff (reset)
      playing_ff |-> (left_ff != '0))
      else $error("tone playing with zero samples left");

   a_tick_advances_phase: assert property (@(posedge clock) disable iff (reset)
      (step_en && (item.cmd == CMD_TICK) && playing_ff)
      |=> (phase_ff == $past(phase_ff) + $past(step_ff)))
      else $error("phase did not advance on tick");

   a_volume_saturated: assert property (@(posedge clock) disable iff (reset)
      vol_ff <= VOL_MAX)
      else $error("volume above full scale");

endmodule

// File: src/square_tone_generator.sv
// Square-wave test-tone generator. Each req beat carries a command in tuser
// (start, stop or sample tick) and its arguments in tdata; each one produces
// exactly one rsp beat with the tick's PCM sample (if any) and the current
// status and wrap-around counters. A start is checked (amplifier on, idle,
// 100..5000 Hz, 1..2000 ms) and sets a 32-bit phase step of
// freq * 2^32 / SAMPLE_RATE and a sample count of SAMPLE_RATE * ms / 1000.
// Throughput is one beat per clock while the rsp side keeps up. From req accept,
// a beat passes the input register, then three register stages that evaluate
// both constant divides (split into exact part and remainder, reciprocal
// multiply, back-multiply); the one-step correction and the tone-state update
// then feed the rsp output register. The tone state updates once per beat, so
// back-to-back starts and ticks see each other's effect. A stalled rsp side
// fills the internal stages before req_tready drops. Register writes on csr_*
// take effect on the next edge and must only be issued while no beat is in
// flight.
module square_tone_generator
   import sqtone_pkg::*;
#(
   parameter int SAMPLE_RATE = 16000
) (
   input  logic                  clock,
   input  logic                  reset,
   // req: tdata = tone_hz[15:0], tone_ms[31:16], sink_accepted[32]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,
   input  logic [1:0]            req_tuser,   // command[1:0]
   // rsp: tdata = sample[15:0], sample_valid[16], start_accepted[17],
   //      playing[18], underrun[19], rejected_count[35:20],
   //      completed_count[51:36]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [55:0]           rsp_tdata,
   // register write port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // 2^32 = SAMPLE_RATE * StepQuot + StepRem
   localparam logic [63:0] Two32    = 64'h1_0000_0000;
   localparam int          RemW     = $clog2(SAMPLE_RATE);
   localparam int          RateW    = RemW + 1;          // holds < 2*SAMPLE_RATE
   localparam logic [31:0] StepQuot = 32'(Two32 / 64'(SAMPLE_RATE));
   localparam logic [RemW-1:0] StepRem = RemW'(Two32 % 64'(SAMPLE_RATE));
   localparam int          XW       = 16 + RemW;
   // SAMPLE_RATE = 1000 * DurHi + DurLo
   localparam int          DurHiW   = $clog2(SAMPLE_RATE / MS_PER_S + 1);
   localparam logic [DurHiW-1:0]   DurHi = DurHiW'(SAMPLE_RATE / MS_PER_S);
   localparam logic [MS_REM_W-1:0] DurLo = MS_REM_W'(SAMPLE_RATE % MS_PER_S);
   localparam int          YW       = 16 + MS_REM_W;

   typedef struct packed {
      item_type    item;
      logic [31:0] hi;     // freq * StepQuot
      logic [XW-1:0] x;    // freq * StepRem, still to be divided
      logic [15:0] dl;     // dur * DurHi
      logic [YW-1:0] y;    // dur * DurLo, still to be divided by 1000
   } s2_type;

   typedef struct packed {
      item_type    item;
      logic [31:0] hi;
      logic [XW-1:0] x;
      logic [15:0] qx;     // estimate, may be one low
      logic [15:0] dl;
      logic [YW-1:0] y;
      logic [15:0] qy;
   } s3_type;

   typedef struct packed {
      item_type    item;
      logic [31:0] hi;
      logic [15:0] qx;
      logic [RateW-1:0] rx;
      logic [15:0] dl;
      logic [15:0] qy;
      logic [MS_REM_W:0] ry;
   } s4_type;

   logic     v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   item_type p1_ff, p1_in;
   s2_type   p2_ff, p2_in;
   s3_type   p3_ff, p3_in;
   s4_type   p4_ff, p4_in;
   rsp_type  rsp_ff, rsp_in;

   logic rdy1, rdy2, rdy3, rdy4, out_move;

   logic [XW+31:0]        qx_prod;
   logic [YW+22:0]        qy_prod;
   logic [31:0]           qx_sr;
   logic [YW-1:0]         qy_ms;
   logic [31:0]           step_calc;
   logic [15:0]           count_calc;

   // Stall chain: a stage loads whenever it is empty or its beat moves on.
   assign out_move   = !rsp_valid_ff || rsp_tready;
   assign rdy4       = !v4_ff || out_move;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   always_comb begin
      p1_in.cmd           = cmd_type'(req_tuser);
      p1_in.tone_hz       = req_tdata[15:0];
      p1_in.tone_ms       = req_tdata[31:16];
      p1_in.sink_accepted = req_tdata[32];

      // stage 2: split both quotients into an exact part and a remainder
      p2_in.item = p1_ff;
      p2_in.hi   = 32'(p1_ff.tone_hz * StepQuot);
      p2_in.x    = XW'(p1_ff.tone_hz * StepRem);
      p2_in.dl   = 16'(p1_ff.tone_ms * DurHi);
      p2_in.y    = YW'(p1_ff.tone_ms * DurLo);

      // stage 3: reciprocal estimates, never high and at most one low
      qx_prod     = (XW+32)'(p2_ff.x) * (XW+32)'(StepQuot);
      qy_prod     = (YW+23)'(p2_ff.y) * (YW+23)'(MS_RECIP);
      p3_in.item  = p2_ff.item;
      p3_in.hi    = p2_ff.hi;
      p3_in.x     = p2_ff.x;
      p3_in.qx    = 16'(qx_prod >> 32);
      p3_in.dl    = p2_ff.dl;
      p3_in.y     = p2_ff.y;
      p3_in.qy    = 16'(qy_prod >> 32);

      // stage 4: remainders of the estimates
      qx_sr       = 32'(p3_ff.qx) * 32'(SAMPLE_RATE);
      qy_ms       = YW'(32'(p3_ff.qy) * 32'(MS_PER_S));
      p4_in.item  = p3_ff.item;
      p4_in.hi    = p3_ff.hi;
      p4_in.qx    = p3_ff.qx;
      p4_in.rx    = RateW'(32'(p3_ff.x) - qx_sr);
      p4_in.dl    = p3_ff.dl;
      p4_in.qy    = p3_ff.qy;
      p4_in.ry    = (MS_REM_W+1)'(p3_ff.y - qy_ms);

      // correction step, consumed by the state update
      step_calc  = p4_ff.hi + 32'(p4_ff.qx)
                 + 32'(p4_ff.rx >= RateW'(SAMPLE_RATE));
      count_calc = p4_ff.dl + p4_ff.qy
                 + 16'(p4_ff.ry >= (MS_REM_W+1)'(MS_PER_S));
   end

   sqtone_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (v4_ff && out_move),
      .item       (p4_ff.item),
      .step_calc  (step_calc),
      .count_calc (count_calc),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .result     (rsp_in)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (out_move) rsp_valid_ff <= v4_ff;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (rdy1) p1_ff <= p1_in;
      if (rdy2) p2_ff <= p2_in;
      if (rdy3) p3_ff <= p3_in;
      if (rdy4) p4_ff <= p4_in;
      if (out_move) rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_ff};

   a_start_means_playing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.start_accepted) |-> rsp_ff.playing)
      else $error("accepted start not reported as playing");

   a_start_no_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.start_accepted && rsp_ff.sample_valid))
      else $error("start beat carries a sample");

   a_idle_sample_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.sample_valid) |-> (rsp_ff.sample == '0))
      else $error("sample nonzero without sample_valid");

endmodule

// File: verif/square_tone_generator_checker.sv
module square_tone_generator_checker
   import sqtone_pkg::*;
#(
   parameter int SAMPLE_RATE = 16000
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [39:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [55:0]           rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);

   localparam int FULL_SCALE = 28000;
   localparam int PCT_SCALE  = 100;
   localparam int REPORT_MAX = 10;

   // shadow of the registers and the tone state
   logic [6:0]  volume_pct;
   logic        amp_on;
   logic [31:0] phase_acc;
   logic [31:0] phase_step;
   logic [15:0] samples_left;
   logic        tone_on;
   logic        underrun_seen;
   logic [15:0] rejected_total;
   logic [15:0] completed_total;

   rsp_type expected_status[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // applies one beat to the shadow state, returns the status it should produce
   function automatic rsp_type tone_step(input logic [1:0] cmd, input logic [15:0] freq,
                                         input logic [15:0] dur, input logic sink_ok);
      rsp_type     status;
      logic [15:0] amp;
      logic [63:0] wide;
      status = '0;
      case (cmd)
         CMD_START: begin
            if (!amp_on || tone_on || freq < FREQ_MIN || freq > FREQ_MAX ||
                dur == 16'd0 || dur > DUR_MAX) begin
               rejected_total = rejected_total + 16'd1;
            end else begin
               phase_acc     = '0;
               wide          = {freq, 32'd0} / 64'(SAMPLE_RATE);
               phase_step    = wide[31:0];
               wide          = 64'(SAMPLE_RATE) * dur / MS_PER_S;
               samples_left  = wide[15:0];
               tone_on       = (samples_left != 16'd0);
               underrun_seen = 1'b0;
               status.start_accepted = tone_on;
            end
         end
         CMD_STOP: begin
            samples_left = '0;
            tone_on      = 1'b0;
         end
         CMD_TICK: begin
            if (tone_on && samples_left != 16'd0) begin
               amp = 16'(FULL_SCALE * volume_pct / PCT_SCALE);
               status.sample       = phase_acc[31] ? amp : -amp;
               status.sample_valid = 1'b1;
               phase_acc = phase_acc + phase_step;
               if (sink_ok) samples_left = samples_left - 16'd1;
               else underrun_seen = 1'b1;
               if (samples_left == 16'd0) begin
                  tone_on         = 1'b0;
                  completed_total = completed_total + 16'd1;
               end
            end
         end
         default: ;
      endcase
      status.playing         = tone_on;
      status.underrun        = underrun_seen;
      status.rejected_count  = rejected_total;
      status.completed_count = completed_total;
      return status;
   endfunction

   function automatic void note_field(input string name, input int want, input int got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= REPORT_MAX)
            $display("%0t rsp %s: expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch_beats
      rsp_type got;
      rsp_type want;
      if (reset) begin
         volume_pct      = VOL_RESET;
         amp_on          = 1'b0;
         phase_acc       = '0;
         phase_step      = '0;
         samples_left    = '0;
         tone_on         = 1'b0;
         underrun_seen   = 1'b0;
         rejected_total  = '0;
         completed_total = '0;
         expected_status.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_W-1:0];
            if (expected_status.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("%0t rsp beat %h with nothing outstanding", $time, rsp_tdata);
            end else begin
               want = expected_status.pop_front();
               note_field("sample", want.sample, got.sample);
               note_field("sample_valid", want.sample_valid, got.sample_valid);
               note_field("start_accepted", want.start_accepted, got.start_accepted);
               note_field("playing", want.playing, got.playing);
               note_field("underrun", want.underrun, got.underrun);
               note_field("rejected_count", want.rejected_count, got.rejected_count);
               note_field("completed_count", want.completed_count, got.completed_count);
            end
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_VOLUME: volume_pct = (csr_wdata > VOL_MAX) ? VOL_MAX : csr_wdata;
               CSR_AMP: begin
                  amp_on = csr_wdata[0];
                  if (!amp_on) begin
                     samples_left = '0;
                     tone_on      = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_status.push_back(tone_step(req_tuser, req_tdata[15:0],
                                                req_tdata[31:16], req_tdata[32]));
      end
      pending_count = expected_status.size();
   end

endmodule

// File: verif/square_tone_generator_tb.sv
module square_tone_generator_tb;
   import sqtone_pkg::*;

   localparam int SAMPLE_RATE  = 16000;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PCT     = 21;
   localparam int PHASE_BEATS  = 95;
   localparam int OFF_BEATS    = 40;
   localparam int NUM_PHASES   = 9;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 16;

   // tuser code the block has no use for
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // amp enable lives in bit 0 only; the upper bits are don't-care
   localparam logic [CSR_DATA_W-1:0] AMP_ON_LOW   = 7'h01;
   localparam logic [CSR_DATA_W-1:0] AMP_ON_ALL   = 7'h7F;
   localparam logic [CSR_DATA_W-1:0] AMP_OFF_NONE = 7'h00;
   localparam logic [CSR_DATA_W-1:0] AMP_OFF_ALL  = 7'h7E;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [39:0]           req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [55:0]           rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int fail_count;
   int pending_count;
   int beats_sent    = 0;
   int cycle_count   = 0;
   int send_idle_pct = IDLE_PCT;
   int take_idle_pct = IDLE_PCT;
   // the stimulus bumps hold_asks; the rsp side notices and holds off on its own
   int hold_asks     = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   square_tone_generator #(.SAMPLE_RATE(SAMPLE_RATE)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   square_tone_generator_checker #(.SAMPLE_RATE(SAMPLE_RATE)) tone_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // rsp side: random stalls, plus a long hold-off whenever one is asked for
   always @(negedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = ($urandom_range(99) >= take_idle_pct);
      end
   end

   // One req beat. Called at a falling edge, returns at the falling edge after
   // the accept. tvalid stays high on return so back-to-back beats have no gap.
   task automatic send_beat(input logic [1:0] cmd, input logic [15:0] freq,
                            input logic [15:0] dur, input logic sink_ok);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      // tdata: tone_hz, tone_ms, sink_accepted, zero pad
      req_tdata  = {7'd0, sink_ok, dur, freq};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   // park the req side until every predicted rsp beat has come back
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // register writes only with the pipe empty
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      csr_we    = 1'b1;
      csr_addr  = addr;
      csr_wdata = data;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // A start with legal arguments followed by the ticks to play it out. Mostly
   // 1 ms tones (16 samples) so that many of them complete; now and then a long
   // one that gets cut off by a stop. A few stray beats land inside the tone.
   task automatic play_tone();
      logic [15:0] freq;
      logic [15:0] dur;
      int          ticks;
      int          pick;
      if ($urandom_range(1)) send_beat(CMD_STOP, 16'($urandom), 16'($urandom), 1'($urandom));
      pick = $urandom_range(9);
      freq = (pick == 0) ? FREQ_MIN :
             (pick == 1) ? FREQ_MAX : 16'($urandom_range(FREQ_MAX, FREQ_MIN));
      pick = $urandom_range(19);
      dur  = (pick == 0) ? 16'($urandom_range(DUR_MAX, 4)) :
             (pick < 12) ? 16'd1 : 16'($urandom_range(3, 2));
      ticks = (dur <= 16'd3) ? SAMPLE_RATE * dur / MS_PER_S + $urandom_range(4)
                             : $urandom_range(40, 5);
      send_beat(CMD_START, freq, dur, 1'($urandom));
      repeat (ticks) begin
         pick = $urandom_range(99);
         if (pick < 3)
            send_beat(CMD_START, 16'($urandom), 16'($urandom), 1'($urandom));
         else if (pick < 5)
            send_beat(CMD_UNUSED, 16'($urandom), 16'($urandom), 1'($urandom));
         else if (pick < 6)
            send_beat(CMD_STOP, 16'($urandom), 16'($urandom), 1'($urandom));
         else
            // sink refuses about one sample in twelve
            send_beat(CMD_TICK, 16'($urandom), 16'($urandom), $urandom_range(99) < 92);
      end
      if (dur > 16'd3) send_beat(CMD_STOP, 16'($urandom), 16'($urandom), 1'($urandom));
   endtask

   // mostly well-formed tones, the rest raw noise over all four tuser codes
   task automatic random_traffic(input int target);
      while (beats_sent < target) begin
         if ($urandom_range(99) < 70)
            play_tone();
         else
            send_beat(2'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
      end
   endtask

   initial begin : stimulus
      int                    phase_end;
      int                    phase_len;
      logic [CSR_DATA_W-1:0] vol_bits;
      logic [CSR_DATA_W-1:0] amp_bits;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed ---
      // out of reset the amp is off: start rejected, tick does nothing
      send_beat(CMD_START, 16'd1000, 16'd10, 1'b1);
      send_beat(CMD_TICK, 16'hFFFF, 16'hFFFF, 1'b1);
      send_beat(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
      send_beat(CMD_STOP, 16'h0000, 16'h0000, 1'b0);
      csr_write(CSR_AMP, AMP_ON_LOW);

      // each argument check just outside its window
      send_beat(CMD_START, FREQ_MIN - 16'd1, 16'd10, 1'b0);
      send_beat(CMD_START, FREQ_MAX + 16'd1, 16'd10, 1'b1);
      send_beat(CMD_START, 16'h0000, 16'h0000, 1'b0);
      send_beat(CMD_START, 16'hFFFF, 16'hFFFF, 1'b1);
      send_beat(CMD_START, 16'd1000, 16'd0, 1'b1);
      send_beat(CMD_START, 16'd1000, DUR_MAX + 16'd1, 1'b0);

      // top frequency, longest tone; the phase MSB flips within three samples
      send_beat(CMD_START, FREQ_MAX, DUR_MAX, 1'b1);
      send_beat(CMD_TICK, 16'h0000, 16'h0000, 1'b0);    // sink refuses: underrun
      send_beat(CMD_START, FREQ_MIN, 16'd1, 1'b1);      // busy: rejected
      send_beat(CMD_TICK, 16'hFFFF, 16'hFFFF, 1'b1);
      send_beat(CMD_TICK, 16'h0000, 16'h0000, 1'b1);
      send_beat(CMD_UNUSED, 16'h0000, 16'h0000, 1'b0);  // mid-tone, no effect
      send_beat(CMD_STOP, 16'hFFFF, 16'hFFFF, 1'b1);
      send_beat(CMD_TICK, 16'h0000, 16'h0000, 1'b1);    // idle again

      // amp switched off under a running tone kills it
      send_beat(CMD_START, FREQ_MIN, 16'd1, 1'b1);
      send_beat(CMD_TICK, 16'h0000, 16'h0000, 1'b1);
      csr_write(CSR_AMP, AMP_OFF_NONE);
      send_beat(CMD_TICK, 16'h0000, 16'h0000, 1'b1);
      send_beat(CMD_START, FREQ_MIN, 16'd1, 1'b1);

      // --- random phases, one register setting each ---
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         phase_len     = PHASE_BEATS;
         amp_bits      = AMP_ON_ALL;
         send_idle_pct = IDLE_PCT;
         take_idle_pct = IDLE_PCT;
         case (phase)
            0: vol_bits = VOL_MAX;
            1: vol_bits = 7'd0;
            2: begin
               // saturating write, and the stretch with both sides flat out
               vol_bits      = 7'h7F;
               send_idle_pct = 0;
               take_idle_pct = 0;
            end
            3: vol_bits = 7'd1;
            4: vol_bits = VOL_MAX + 7'd1;
            5: begin
               // amp off for the whole phase: every start bounces
               vol_bits  = 7'($urandom);
               amp_bits  = AMP_OFF_ALL;
               phase_len = OFF_BEATS;
            end
            6: vol_bits = 7'd55;
            default: vol_bits = 7'($urandom);
         endcase
         csr_write(CSR_VOLUME, vol_bits);
         csr_write(CSR_AMP, amp_bits);
         phase_end = beats_sent + phase_len;
         // back-pressure: rsp side stalls while req keeps offering, pipe fills up
         if (phase == 4) hold_asks++;
         if (phase == 6) begin
            random_traffic(beats_sent + phase_len / 2);
            wait_drained();
         end
         random_traffic(phase_end);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
